### sv/cnlc_pkg.sv
// Shared types, constants and helpers for the card number Luhn classifier.
// No dependencies; every other file of the block depends on this package.
package cnlc_pkg;

    localparam int NUM_BITS   = 63;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 19;
    localparam int MAX_DIGITS = 19;
    localparam int BIT_CNT_W  = $clog2(NUM_BITS);
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;

    localparam logic [1:0] BRAND_NONE  = 2'd0;
    localparam logic [1:0] BRAND_FOUR  = 2'd1;
    localparam logic [1:0] BRAND_THREE = 2'd2;
    localparam logic [1:0] BRAND_FIVE  = 2'd3;

    localparam logic [CNT_W-1:0] LEN_13 = CNT_W'(13);
    localparam logic [CNT_W-1:0] LEN_15 = CNT_W'(15);
    localparam logic [CNT_W-1:0] LEN_16 = CNT_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_FINISH
    } cnlc_state_t;

    typedef struct packed {
        logic start;
        logic shift;
    } cnlc_conv_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cnlc_conv_stat_t;

    // digit sum of twice a decimal digit
    function automatic logic [DIGIT_W-1:0] dbl_digit_sum(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] r;
        begin
            unique case (d)
                4'd0:    r = 4'd0;
                4'd1:    r = 4'd2;
                4'd2:    r = 4'd4;
                4'd3:    r = 4'd6;
                4'd4:    r = 4'd8;
                4'd5:    r = 4'd1;
                4'd6:    r = 4'd3;
                4'd7:    r = 4'd5;
                4'd8:    r = 4'd7;
                4'd9:    r = 4'd9;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### sv/cnlc_if.sv
// Valid/ready channel interfaces for card numbers in and classification results out.
// Depends on cnlc_pkg for field widths.
interface cnlc_in_if;
    logic                           valid;
    logic                           ready;
    logic [cnlc_pkg::NUM_BITS-1:0]  card_number;

    modport source (output valid, output card_number, input ready);
    modport sink   (input valid, input card_number, output ready);
endinterface

interface cnlc_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     brand;
    logic                           luhn_ok;
    logic [cnlc_pkg::CNT_W-1:0]     digit_count;

    modport source (output valid, output brand, output luhn_ok, output digit_count,
                    input ready);
    modport sink   (input valid, input brand, input luhn_ok, input digit_count,
                    output ready);
endinterface

### sv/cnlc_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), with a digit shift-out path.
// Depends on cnlc_pkg.
module cnlc_bcd_conv (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cnlc_pkg::cnlc_conv_ctrl_t       ctrl,
    input  logic [cnlc_pkg::NUM_BITS-1:0]   number,
    output cnlc_pkg::cnlc_conv_stat_t       stat,
    output logic [cnlc_pkg::DIGIT_W-1:0]    lsd
);
    import cnlc_pkg::*;

    logic [NUM_BITS-1:0]  bin_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     adj;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        if (ctrl.start)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = '0;
        end
        else if (busy_reg)
        begin
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (bit_cnt_reg == BIT_CNT_W'(NUM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            bin_reg <= number;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[NUM_BITS-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[NUM_BITS-1]};
        end
        else if (ctrl.shift)
        begin
            // least significant digit leaves first
            bcd_reg <= {{DIGIT_W{1'b0}}, bcd_reg[BCD_W-1:DIGIT_W]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign lsd       = bcd_reg[DIGIT_W-1:0];

endmodule

### sv/card_number_luhn_classifier_unit.sv
// Card number Luhn classifier: top level.
// Flow: an input beat is converted bit by bit in the shift-and-add-3 converter, a handoff
// step follows, the digits are scanned least significant first, then the result is finished.
// A new card number is taken only in the idle state, once the previous one has finished; the next
// beat is taken even while a result waits in the output register, but finish stalls on it.
// Reset: rst_n asynchronous, active low; clears the state machine and valid flags.
module card_number_luhn_classifier_unit (
    input  logic        clk,
    input  logic        rst_n,
    cnlc_in_if.sink     card_in,
    cnlc_out_if.source  result_out
);
    import cnlc_pkg::*;

    cnlc_state_t          state_reg, state_next;
    cnlc_conv_ctrl_t      conv_ctrl;
    cnlc_conv_stat_t      conv_stat;
    logic [DIGIT_W-1:0]   digit;

    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIGIT_W-1:0]   sum_reg;
    logic [DIGIT_W-1:0]   lead1_reg;
    logic [DIGIT_W-1:0]   lead2_reg;
    logic [DIGIT_W-1:0]   prev_reg;

    logic                 out_valid_reg;
    logic [1:0]           out_brand_reg;
    logic                 out_ok_reg;
    logic [CNT_W-1:0]     out_cnt_reg;

    logic                 scan_last;
    logic                 out_free;
    logic                 finish;
    logic [DIGIT_W-1:0]   addend;
    logic [DIGIT_W:0]     sum_raw;
    logic [DIGIT_W-1:0]   sum_next;
    logic                 num_valid;
    logic                 ok;
    logic [1:0]           brand;

    cnlc_bcd_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (conv_ctrl),
        .number (card_in.card_number),
        .stat   (conv_stat),
        .lsd    (digit)
    );

    assign scan_last = (idx_reg == CNT_W'(NUM_DIGITS - 1));
    assign out_free  = !out_valid_reg || result_out.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (card_in.valid) state_next = ST_CONV;
            ST_CONV:   if (conv_stat.done) state_next = ST_SCAN;
            ST_SCAN:   if (scan_last) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        card_in.ready   = 1'b0;
        conv_ctrl.start = 1'b0;
        conv_ctrl.shift = 1'b0;
        finish          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                card_in.ready   = 1'b1;
                conv_ctrl.start = card_in.valid;
            end
            ST_CONV:   ;
            ST_SCAN:   conv_ctrl.shift = 1'b1;
            ST_FINISH: finish = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Luhn sum kept modulo ten; even positions (from the right, counting from zero) as is
    assign addend   = idx_reg[0] ? dbl_digit_sum(digit) : digit;
    assign sum_raw  = {1'b0, sum_reg} + {1'b0, addend};
    assign sum_next = (sum_raw >= 5'd10) ? DIGIT_W'(sum_raw - 5'd10)
                                         : sum_raw[DIGIT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (conv_ctrl.start)
        begin
            idx_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            lead1_reg <= '0;
            lead2_reg <= '0;
            prev_reg  <= '0;
        end
        else if (conv_ctrl.shift)
        begin
            idx_reg  <= idx_reg + 1'b1;
            sum_reg  <= sum_next;
            prev_reg <= digit;
            // highest nonzero digit seen so far sets length and prefix
            if (digit != '0)
            begin
                cnt_reg   <= idx_reg + 1'b1;
                lead1_reg <= digit;
                lead2_reg <= prev_reg;
            end
        end
    end

    assign num_valid = (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_DIGITS));
    assign ok        = num_valid && (sum_reg == '0);

    always_comb
    begin
        brand = BRAND_NONE;
        priority if (!ok)
            brand = BRAND_NONE;
        else if (lead1_reg == 4'd4 && (cnt_reg == LEN_13 || cnt_reg == LEN_16))
            brand = BRAND_FOUR;
        else if (lead1_reg == 4'd3 && (lead2_reg == 4'd4 || lead2_reg == 4'd7)
                 && cnt_reg == LEN_15)
            brand = BRAND_THREE;
        else if (lead1_reg == 4'd5 && lead2_reg >= 4'd1 && lead2_reg <= 4'd5
                 && cnt_reg == LEN_16)
            brand = BRAND_FIVE;
        else
            brand = BRAND_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_brand_reg <= brand;
            out_ok_reg    <= ok;
            out_cnt_reg   <= cnt_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.brand       = out_brand_reg;
    assign result_out.luhn_ok     = out_ok_reg;
    assign result_out.digit_count = out_cnt_reg;

endmodule
